>>> rtl/sliding_window_maximum_core_defines.svh
// ---------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked out of reset only
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SWM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(lbl, prop, msg)
`define SWM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/swm_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window maximum package
// Payload types, cell control bundle and shared constants.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int SWM_SAMPLE_W       = 16;
  localparam int SWM_WIN_CFG_W      = 7;
  localparam int SWM_WINDOW_MAX_DEF = 64;
  localparam logic [SWM_WIN_CFG_W-1:0] SWM_WIN_RESET = 7'd3;

  typedef struct packed {
    logic signed [SWM_SAMPLE_W-1:0] sample;
    logic                           last;
  } in_item_t;

  typedef struct packed {
    logic signed [SWM_SAMPLE_W-1:0] window_max;
    logic                           end_of_stream;
  } out_item_t;

  // broadcast to every cell of the deque chain
  typedef struct packed {
    logic                           shift;   // move every entry one cell to the front
    logic                           commit;  // pop smaller entries, append sample
    logic                           flush;   // end of stream: drop all entries
    logic signed [SWM_SAMPLE_W-1:0] sample;
  } cell_ctl_t;

endpackage

>>> rtl/swm_cell.sv
// ---------------------------------------------------------------------------
// Sliding window maximum: deque cell
// Holds one candidate (value, position). Takes its neighbour's entry on a
// front eviction, drops itself when beaten by the new sample, and takes the
// sample when it is the first free cell behind the kept entries.
// ---------------------------------------------------------------------------
module swm_cell #(
  parameter int PW = 7
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  swm_pkg::cell_ctl_t                      ctl_i,
  input  logic [PW-1:0]                           now_i,
  input  logic                                    nb_valid_i,
  input  logic signed [swm_pkg::SWM_SAMPLE_W-1:0] nb_value_i,
  input  logic [PW-1:0]                           nb_pos_i,
  input  logic                                    prev_keep_i,
  output logic                                    valid_o,
  output logic signed [swm_pkg::SWM_SAMPLE_W-1:0] value_o,
  output logic [PW-1:0]                           pos_o,
  output logic                                    keep_o,
  output logic signed [swm_pkg::SWM_SAMPLE_W-1:0] head_value_o
);
  import swm_pkg::*;

  logic                           valid_r, valid_nxt;
  logic signed [SWM_SAMPLE_W-1:0] value_r, value_nxt;
  logic [PW-1:0]                  pos_r, pos_nxt;

  logic                           v_valid;
  logic signed [SWM_SAMPLE_W-1:0] v_value;
  logic [PW-1:0]                  v_pos;
  logic                           popped;
  logic                           keep;
  logic                           wr;

  always_comb begin
    v_valid   = ctl_i.shift ? nb_valid_i : valid_r;
    v_value   = ctl_i.shift ? nb_value_i : value_r;
    v_pos     = ctl_i.shift ? nb_pos_i   : pos_r;
    // equal values survive
    popped    = v_valid && ctl_i.commit && (v_value < ctl_i.sample);
    keep      = v_valid && !popped;
    wr        = ctl_i.commit && prev_keep_i && !keep;
    valid_nxt = ctl_i.flush ? 1'b0 : (keep || wr);
    value_nxt = wr ? ctl_i.sample : v_value;
    pos_nxt   = wr ? now_i : v_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

  assign valid_o      = valid_r;
  assign value_o      = value_r;
  assign pos_o        = pos_r;
  assign keep_o       = keep;
  assign head_value_o = value_nxt;

endmodule

>>> rtl/sliding_window_maximum_core.sv
// Each sample is registered on transfer; its result is registered at the output when it commits.
// Throughput: one sample per cycle while at most one candidate leaves the front
//   per sample; each further front eviction (after window_len is shortened)
//   is done as a separate shift of the deque cell chain. A result stalled at the
//   output register holds the sample in flight.
// Reset (synchronous, rst_n low): deque emptied, counters cleared, window_len = 3.
// ---------------------------------------------------------------------------
// Sliding window maximum core
// Running maximum of the last window_len samples, kept as a monotonic deque
// in a chain of cells, front at cell 0.
// ---------------------------------------------------------------------------
`include "sliding_window_maximum_core_defines.svh"

module sliding_window_maximum_core #(
  parameter int WINDOW_MAX = swm_pkg::SWM_WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  swm_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output swm_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swm_pkg::SWM_WIN_CFG_W-1:0]  cfg_data
);
  import swm_pkg::*;

  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int PW      = $clog2(POS_MOD);
  localparam int CW      = $clog2(WINDOW_MAX + 1);

  // configuration
  logic [SWM_WIN_CFG_W-1:0] win_cfg_r;
  logic [CW-1:0]            eff_win;

  // sample in flight
  logic                     hold_v_r, hold_v_nxt;
  in_item_t                 hold_r;

  // stream counters
  logic [PW-1:0]            now_r, now_nxt;
  logic [CW-1:0]            fill_r, fill_nxt, fill_inc;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r;

  // cell chain
  logic [WINDOW_MAX-1:0]                    cv;
  logic signed [SWM_SAMPLE_W-1:0]           cval  [WINDOW_MAX];
  logic [PW-1:0]                            cpos  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]                    ckeep;
  logic signed [SWM_SAMPLE_W-1:0]           chead [WINDOW_MAX];
  cell_ctl_t                                ctl;

  logic [PW-1:0] age0, age1;
  logic          evict0, evict1;
  logic          produce, out_free, done;

  // window length: zero means one, anything above the deque depth saturates
  always_comb begin
    if (win_cfg_r == '0) begin
      eff_win = CW'(1);
    end else if (32'(win_cfg_r) > 32'(WINDOW_MAX)) begin
      eff_win = CW'(WINDOW_MAX);
    end else begin
      eff_win = CW'(win_cfg_r);
    end
  end

  // age modulo the position range
  always_comb begin
    age0   = now_r - cpos[0] + ((now_r < cpos[0]) ? PW'(POS_MOD) : '0);
    age1   = now_r - cpos[1] + ((now_r < cpos[1]) ? PW'(POS_MOD) : '0);
    evict0 = cv[0] && (32'(age0) >= 32'(eff_win));
    evict1 = cv[1] && (32'(age1) >= 32'(eff_win));
  end

  always_comb begin
    fill_inc = (32'(fill_r) < 32'(WINDOW_MAX)) ? fill_r + CW'(1) : fill_r;
    produce  = 32'(fill_inc) >= 32'(eff_win);
    out_free = !out_valid_r || out_ready;
    // two stale entries at the front: shift once and retry next cycle
    done     = hold_v_r && !(evict0 && evict1) && (!produce || out_free);

    ctl.shift  = hold_v_r && evict0 && (evict1 || done);
    ctl.commit = done;
    ctl.flush  = done && hold_r.last;
    ctl.sample = hold_r.sample;

    hold_v_nxt = (in_valid && in_ready) ? 1'b1 : (done ? 1'b0 : hold_v_r);

    now_nxt  = now_r;
    fill_nxt = fill_r;
    if (done) begin
      if (hold_r.last) begin
        now_nxt  = '0;
        fill_nxt = '0;
      end else begin
        now_nxt  = (32'(now_r) == POS_MOD - 1) ? '0 : now_r + PW'(1);
        fill_nxt = fill_inc;
      end
    end

    if (done && produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      logic                           nb_valid;
      logic signed [SWM_SAMPLE_W-1:0] nb_value;
      logic [PW-1:0]                  nb_pos;
      logic                           prev_keep;

      if (gi == WINDOW_MAX - 1) begin : g_tail
        assign nb_valid = 1'b0;
        assign nb_value = '0;
        assign nb_pos   = '0;
      end else begin : g_body
        assign nb_valid = cv[gi+1];
        assign nb_value = cval[gi+1];
        assign nb_pos   = cpos[gi+1];
      end

      if (gi == 0) begin : g_front
        assign prev_keep = 1'b1;
      end else begin : g_rest
        assign prev_keep = ckeep[gi-1];
      end

      swm_cell #(
        .PW (PW)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .now_i        (now_r),
        .nb_valid_i   (nb_valid),
        .nb_value_i   (nb_value),
        .nb_pos_i     (nb_pos),
        .prev_keep_i  (prev_keep),
        .valid_o      (cv[gi]),
        .value_o      (cval[gi]),
        .pos_o        (cpos[gi]),
        .keep_o       (ckeep[gi]),
        .head_value_o (chead[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r   <= SWM_WIN_RESET;
      hold_v_r    <= 1'b0;
      now_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        win_cfg_r <= cfg_data;
      end
      hold_v_r    <= hold_v_nxt;
      now_r       <= now_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= in_data;
    end
    if (done && produce) begin
      out_r.window_max    <= chead[0];
      out_r.end_of_stream <= hold_r.last;
    end
  end

  assign in_ready  = !hold_v_r || done;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // occupied cells always form a prefix of the chain
  `SWM_ASSERT(a_deque_prefix, (cv[WINDOW_MAX-1:1] & ~cv[WINDOW_MAX-2:0]) == '0, "deque has a hole")
  // an append always finds a free cell
  `SWM_ASSERT(a_no_overflow, ctl.commit |-> (!cv[WINDOW_MAX-1] || ctl.shift), "deque overflow on append")
  // end of stream empties the deque and restarts the counters
  `SWM_ASSERT(a_flush, (done && hold_r.last) |=> (!cv[0] && now_r == '0 && fill_r == '0), "stream state not cleared")
  // reset leaves nothing in flight
  `SWM_ASSERT_RST(a_reset_empty, !rst_n |=> (!hold_v_r && !out_valid_r && cv == '0), "state not cleared by reset")

endmodule

>>> tb/sliding_window_maximum_core_tb.sv
// ---------------------------------------------------------------------------
// Sliding window maximum core testbench
// Drives sample streams through the core and checks every result against a
// monotonic deque kept here. Covers the window register extremes, short
// streams, window changes mid-stream, output backpressure and random streams.
// ---------------------------------------------------------------------------
module sliding_window_maximum_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int WIN_DEPTH       = SWM_WINDOW_MAX_DEF;
  localparam int POS_MOD         = 2 * WIN_DEPTH;
  // a shortened window can evict a whole deque, one cell per cycle
  localparam int DRAIN_CYCLES    = 2 * WIN_DEPTH + 16;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_ITEMS    = 1250;
  localparam int FULL_RATE_ITEMS = 250;

  typedef enum int {
    PAT_RANDOM,
    PAT_NEAR_ZERO,
    PAT_EXTREME,
    PAT_FALLING,
    PAT_RISING
  } pattern_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [SWM_WIN_CFG_W-1:0] cfg_data  = SWM_WIN_RESET;

  // deque kept by the testbench
  logic [SWM_WIN_CFG_W-1:0]       win_len_model = SWM_WIN_RESET;
  logic signed [SWM_SAMPLE_W-1:0] cand_max [WIN_DEPTH];
  int                             cand_at  [WIN_DEPTH];
  int                             cand_cnt = 0;
  int                             next_pos = 0;
  int                             fill_cnt = 0;
  out_item_t                      max_q[$];

  int       errors      = 0;
  int       idle_cycles = 0;
  int       items_sent  = 0;
  int       hold_left   = 0;
  int       rx_gap      = 0;
  bit       idle_en     = 1'b1;
  bit       hold_req    = 1'b0;
  pattern_t pattern     = PAT_RANDOM;
  logic signed [SWM_SAMPLE_W-1:0] ramp = '0;

  sliding_window_maximum_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void predict_window_max(input in_item_t item);
    int        w;
    out_item_t res;
    w = (win_len_model == 0) ? 1 :
        (win_len_model > WIN_DEPTH) ? WIN_DEPTH : int'(win_len_model);
    // evict by age, not by value
    while (cand_cnt > 0 && (next_pos + POS_MOD - cand_at[0]) % POS_MOD >= w) begin
      for (int i = 1; i < cand_cnt; i++) begin
        cand_max[i-1] = cand_max[i];
        cand_at[i-1]  = cand_at[i];
      end
      cand_cnt--;
    end
    // equal candidates stay
    while (cand_cnt > 0 && cand_max[cand_cnt-1] < item.sample)
      cand_cnt--;
    cand_max[cand_cnt] = item.sample;
    cand_at[cand_cnt]  = next_pos;
    cand_cnt++;
    next_pos = (next_pos + 1) % POS_MOD;
    if (fill_cnt < WIN_DEPTH)
      fill_cnt++;
    if (fill_cnt >= w) begin
      res.window_max    = cand_max[0];
      res.end_of_stream = item.last;
      max_q.insert(max_q.size(), res);
    end
    if (item.last) begin
      cand_cnt = 0;
      next_pos = 0;
      fill_cnt = 0;
    end
  endfunction

  // every transfer is seen here, in one place, at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        win_len_model = cfg_data;
      if (in_valid && in_ready) begin
        predict_window_max(in_data);
        items_sent++;
      end
      if (out_valid && out_ready) begin
        if (max_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual window_max %0d end_of_stream %0b",
                   $time, out_data.window_max, out_data.end_of_stream);
        end else begin
          want = max_q[0];
          max_q.delete(0);
          if (out_data.window_max !== want.window_max) begin
            errors++;
            $display("%0t: window_max expected %0d, actual %0d",
                     $time, want.window_max, out_data.window_max);
          end
          if (out_data.end_of_stream !== want.end_of_stream) begin
            errors++;
            $display("%0t: end_of_stream expected %0b, actual %0b",
                     $time, want.end_of_stream, out_data.end_of_stream);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input int value, input bit is_last);
    in_item_t item;
    int       gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.sample = SWM_SAMPLE_W'(value);
    item.last   = is_last;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (max_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input int len);
    wait_idle();
    @(negedge clk);
    cfg_data  <= SWM_WIN_CFG_W'(len);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int next_value();
    case (pattern)
      PAT_NEAR_ZERO: return int'($urandom_range(0, 6)) - 3;
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          default: return -1;
        endcase
      end
      PAT_FALLING: begin
        ramp = ramp - SWM_SAMPLE_W'($urandom_range(0, 3));
        return int'(ramp);
      end
      PAT_RISING: begin
        ramp = ramp + SWM_SAMPLE_W'($urandom_range(0, 3));
        return int'(ramp);
      end
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int pick_window();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return WIN_DEPTH;
      3:       return int'($urandom_range(WIN_DEPTH + 1, 127));
      default: return int'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic run_stream(input int len, input bit retune);
    int cut;
    cut = (retune && len > 1) ? $urandom_range(1, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      if (k == cut)
        write_window(pick_window());
      send_sample(next_value(), k == len - 1);
    end
  endtask

  task automatic run_random_streams(input int item_goal);
    int ew;
    int len;
    while (items_sent < item_goal) begin
      if ($urandom_range(0, 1))
        write_window(pick_window());
      pattern = pattern_t'($urandom_range(0, 4));
      ramp    = SWM_SAMPLE_W'($urandom);
      ew = (win_len_model == 0) ? 1 :
           (win_len_model > WIN_DEPTH) ? WIN_DEPTH : int'(win_len_model);
      case ($urandom_range(0, 7))
        0:       len = $urandom_range(1, ew);
        1:       len = $urandom_range(130, 260);  // stream position wraps
        default: len = ew + $urandom_range(0, 24);
      endcase
      run_stream(len, $urandom_range(0, 7) == 0);
    end
  endtask

  // reset window of 3; extremes and equal values
  task automatic test_default_window();
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(5, 1'b1);
  endtask

  // a stream shorter than the window gives nothing, but still clears
  task automatic test_short_stream();
    write_window(4);
    send_sample(-3, 1'b0);
    send_sample(9, 1'b0);
    send_sample(2, 1'b1);
    send_sample(1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-20, 1'b0);
    send_sample(4, 1'b1);
  endtask

  // zero reads as 1, above the deque depth saturates
  task automatic test_window_limits();
    write_window(0);
    send_sample(7, 1'b0);
    send_sample(-7, 1'b1);
    write_window(127);
    send_sample(100, 1'b0);
    send_sample(-100, 1'b1);
  endtask

  // shorten then lengthen the window in the middle of a stream
  task automatic test_retune_mid_stream();
    write_window(6);
    send_sample(100, 1'b0);
    send_sample(90, 1'b0);
    send_sample(80, 1'b0);
    send_sample(70, 1'b0);
    send_sample(60, 1'b0);
    send_sample(50, 1'b0);
    write_window(2);
    send_sample(40, 1'b0);
    send_sample(45, 1'b0);
    write_window(5);
    send_sample(20, 1'b0);
    send_sample(10, 1'b0);
    send_sample(0, 1'b1);
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_backpressure();
    idle_en = 1'b0;
    write_window(4);
    pattern  = PAT_RANDOM;
    hold_req = 1'b1;
    for (int k = 0; k < 48; k++)
      send_sample(next_value(), k == 47);
    idle_en = 1'b1;
  endtask

  task automatic test_random_streams();
    run_random_streams(RANDOM_ITEMS);
  endtask

  // back to back, no stalls on either side
  task automatic test_full_rate();
    idle_en = 1'b0;
    run_random_streams(items_sent + FULL_RATE_ITEMS);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_default_window();
    test_short_stream();
    test_window_limits();
    test_retune_mid_stream();
    test_output_backpressure();
    test_random_streams();
    test_full_rate();
    wait_idle();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
